@@ rtl/core/bscp_pkg.sv @@
`timescale 1ns / 1ps

package bscp_pkg;

  localparam int POOL_DEPTH_DEF = 64;
  localparam int LIMIT_W        = 7;
  localparam int ID_W           = 32;
  localparam int DIST_W         = 32;
  localparam int POS_W          = 7;
  localparam int STATUS_W       = 2;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // register index, taken from the word address of the port
  localparam logic REG_POOL_LIMIT = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    RES_ADDED     = 2'd0,
    RES_IMPROVED  = 2'd1,
    RES_UNCHANGED = 2'd2,
    RES_REJECTED  = 2'd3
  } bscp_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_WRITE,
    ST_FINISH
  } bscp_state_t;

  typedef struct packed {
    logic load_item;
    logic scan;
    logic decide;
    logic shift_rd;
    logic shift_wr;
    logic write_key;
    logic finish;
  } bscp_cmd_t;

  typedef struct packed {
    logic      scan_done;
    bscp_res_t code;
    logic      need_shift;
    logic      shift_last;
    logic      out_free;
  } bscp_stat_t;

endpackage

@@ rtl/core/bscp_ctrl.sv @@
`timescale 1ns / 1ps

module bscp_ctrl import bscp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  bscp_stat_t stat,
  output bscp_cmd_t  cmd
);

  bscp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_done) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        unique case (stat.code) inside
          RES_ADDED, RES_IMPROVED: begin
            state_next = stat.need_shift ? ST_SHIFT_RD : ST_WRITE;
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_SHIFT_RD: begin
        state_next = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        state_next = stat.shift_last ? ST_WRITE : ST_SHIFT_RD;
      end
      ST_WRITE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
      end
      ST_SCAN:     cmd.scan      = 1'b1;
      ST_DECIDE:   cmd.decide    = 1'b1;
      ST_SHIFT_RD: cmd.shift_rd  = 1'b1;
      ST_SHIFT_WR: cmd.shift_wr  = 1'b1;
      ST_WRITE:    cmd.write_key = 1'b1;
      ST_FINISH:   cmd.finish    = stat.out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

@@ rtl/core/bscp_datapath.sv @@
`timescale 1ns / 1ps

module bscp_datapath import bscp_pkg::*; #(
  parameter  int POOL_DEPTH = POOL_DEPTH_DEF,
  localparam int IDXW       = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
  localparam int CNTW       = $clog2(POOL_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ID_W-1:0]     candidate_id,
  input  logic [DIST_W-1:0]   candidate_distance,
  input  logic [CNTW-1:0]     eff_limit,
  input  logic                out_stall,
  input  bscp_cmd_t           cmd,
  output bscp_stat_t          stat,
  output logic                out_valid,
  output logic [POS_W-1:0]    result_position,
  output logic [STATUS_W-1:0] result_status,
  output logic [POS_W-1:0]    entry_count
);

  localparam int KEY_W = DIST_W + ID_W;

  logic [KEY_W-1:0]  mem [POOL_DEPTH];
  logic [KEY_W-1:0]  rdata;
  logic [IDXW-1:0]   raddr;
  logic              ren;
  logic [IDXW-1:0]   waddr;
  logic [KEY_W-1:0]  wdata;
  logic              wen;

  logic [ID_W-1:0]   key_id;
  logic [DIST_W-1:0] key_dist;
  logic [KEY_W-1:0]  key;
  logic [CNTW-1:0]   cnt;
  logic [CNTW-1:0]   issue_idx;
  logic              rd_pend;
  logic [IDXW-1:0]   rd_idx;
  logic              found;
  logic [IDXW-1:0]   found_idx;
  logic [DIST_W-1:0] found_dist;
  logic              pos_set;
  logic [CNTW-1:0]   pos;
  logic [CNTW-1:0]   mv_idx;
  logic [CNTW-1:0]   mv_prev;
  bscp_res_t         res_code;
  logic [CNTW-1:0]   res_pos;
  logic [POS_W-1:0]  out_pos;
  bscp_res_t         out_code;
  logic [POS_W-1:0]  out_count;

  logic              scan_more;
  logic [CNTW-1:0]   pos_final;
  logic              improved;
  logic              reject;
  bscp_res_t         code;
  logic [CNTW-1:0]   hi;
  logic [CNTW-1:0]   res_pos_next;
  logic              id_hit;
  logic              key_less;

  assign key       = {key_dist, key_id};
  assign scan_more = issue_idx < cnt;
  assign pos_final = pos_set ? pos : cnt;
  assign improved  = found && (key_dist < found_dist);
  assign reject    = !found && (cnt >= eff_limit) && (pos_final == cnt);
  assign mv_prev   = mv_idx - CNTW'(1);
  assign id_hit    = rdata[ID_W-1:0] == key_id;
  assign key_less  = key < rdata;

  always_comb begin
    if (found) begin
      code = improved ? RES_IMPROVED : RES_UNCHANGED;
    end else begin
      code = reject ? RES_REJECTED : RES_ADDED;
    end
  end

  // top of the block of entries that moves down by one place
  always_comb begin
    if (found) begin
      hi = CNTW'(found_idx);
    end else if (cnt < CNTW'(POOL_DEPTH)) begin
      hi = cnt;
    end else begin
      hi = cnt - CNTW'(1);
    end
  end

  assign res_pos_next = (code == RES_UNCHANGED) ? CNTW'(found_idx) : pos_final;

  always_comb begin
    stat            = '0;
    stat.scan_done  = !scan_more && !rd_pend;
    stat.code       = code;
    stat.need_shift = hi != pos_final;
    stat.shift_last = mv_idx == CNTW'(pos + CNTW'(1));
    stat.out_free   = !out_valid || !out_stall;
  end

  // entry store: one read port, one write port, registered read
  assign ren   = (cmd.scan && scan_more) || cmd.shift_rd;
  assign raddr = cmd.scan ? issue_idx[IDXW-1:0] : mv_prev[IDXW-1:0];
  assign wen   = cmd.shift_wr || cmd.write_key;
  assign waddr = cmd.shift_wr ? mv_idx[IDXW-1:0] : pos[IDXW-1:0];
  assign wdata = cmd.shift_wr ? rdata : key;

  always_ff @(posedge clk) begin
    if (ren) rdata <= mem[raddr];
    if (wen) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rd_pend   <= 1'b0;
      found     <= 1'b0;
      pos_set   <= 1'b0;
      out_valid <= 1'b0;
      issue_idx <= '0;
    end else begin
      rd_pend <= cmd.scan && scan_more;
      if (cmd.load_item) begin
        key_id    <= candidate_id;
        key_dist  <= candidate_distance;
        issue_idx <= '0;
        found     <= 1'b0;
        pos_set   <= 1'b0;
      end
      if (cmd.scan && scan_more) begin
        issue_idx <= issue_idx + CNTW'(1);
        rd_idx    <= issue_idx[IDXW-1:0];
      end
      // ids are unique in the pool, so the first hit is the only one
      if (rd_pend) begin
        if (!found && id_hit) begin
          found      <= 1'b1;
          found_idx  <= rd_idx;
          found_dist <= rdata[KEY_W-1:ID_W];
        end
        if (!pos_set && key_less) begin
          pos_set <= 1'b1;
          pos     <= CNTW'(rd_idx);
        end
      end
      if (cmd.decide) begin
        mv_idx   <= hi;
        pos      <= pos_final;
        res_code <= code;
        res_pos  <= res_pos_next;
      end
      if (cmd.shift_wr) begin
        mv_idx <= mv_prev;
      end
      if (cmd.write_key && res_code == RES_ADDED) begin
        if (cnt < CNTW'(POOL_DEPTH) && cnt < eff_limit) begin
          cnt <= cnt + CNTW'(1);
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_pos   <= POS_W'(res_pos);
      out_code  <= res_code;
      out_count <= POS_W'(cnt);
    end
  end

  assign result_position = out_pos;
  assign result_status   = out_code;
  assign entry_count     = out_count;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNTW'(POOL_DEPTH))
    else $error("entry count above store depth");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> CNTW'(rd_idx) < cnt)
    else $error("scan read beyond entry count");

  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.decide && found |-> CNTW'(found_idx) < cnt)
    else $error("matched entry beyond entry count");

  a_shift_order: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_rd |-> (mv_idx > pos) && (mv_idx < CNTW'(POOL_DEPTH)))
    else $error("shift outside insertion range");

  a_finish_held: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("result lost at load");

endmodule

@@ rtl/core/bounded_sorted_candidate_pool.sv @@
`timescale 1ns / 1ps

// Sorted candidate pool for a nearest-neighbour graph search.
// Input channel (in_valid / in_stall) carries candidate_id and
// candidate_distance; a transfer happens when in_valid is high and in_stall
// is low. Each candidate yields exactly one result on the output channel
// (out_valid / out_stall): result_position, result_status, entry_count.
// pool_limit is written through the register port at byte address 0.
// One candidate is handled at a time, from transfer to result. The scan
// reads one entry per cycle through the single read port of the entry
// store, and each entry moved down by one place needs a read and a write.
// in_stall is low only while the block waits for a candidate. The result
// sits in an output register, so the next candidate is taken while it waits;
// a later result waits in its last step until the receiver lifts out_stall.
// Reset empties the pool (no clearing pass, the store is only read below the
// entry count) and sets pool_limit to 64.

module bounded_sorted_candidate_pool import bscp_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ID_W-1:0]       candidate_id,
  input  logic [DIST_W-1:0]     candidate_distance,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [POS_W-1:0]      result_position,
  output logic [STATUS_W-1:0]   result_status,
  output logic [POS_W-1:0]      entry_count,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CNTW = $clog2(POOL_DEPTH + 1);
  localparam int CMPW = (CNTW > LIMIT_W) ? CNTW : LIMIT_W;

  logic [LIMIT_W-1:0] pool_limit;
  logic [CNTW-1:0]    eff_limit;
  bscp_cmd_t          cmd;
  bscp_stat_t         stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_POOL_LIMIT) begin
      pool_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_POOL_LIMIT) prdata = APB_DATA_W'(pool_limit);
  end

  // limit clamped to one up to the store depth
  always_comb begin
    if (pool_limit == '0) begin
      eff_limit = CNTW'(1);
    end else if (CMPW'(pool_limit) > CMPW'(POOL_DEPTH)) begin
      eff_limit = CNTW'(POOL_DEPTH);
    end else begin
      eff_limit = CNTW'(pool_limit);
    end
  end

  bscp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bscp_datapath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .candidate_id       (candidate_id),
    .candidate_distance (candidate_distance),
    .eff_limit          (eff_limit),
    .out_stall          (out_stall),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .result_position    (result_position),
    .result_status      (result_status),
    .entry_count        (entry_count)
  );

endmodule
